### rtl/hrlc_pkg.sv
// ----------------------------------------------------------------------------
// hrlc_pkg
// Types, constants and character codes shared by the request-line checker.
// ----------------------------------------------------------------------------
package hrlc_pkg;

  localparam int unsigned PositionBitsDef = 16;
  localparam int unsigned BytePosW        = 16;
  localparam int unsigned ClassW          = 4;
  localparam int unsigned StatusW         = 2;
  localparam int unsigned DigitW          = 4;

  // character codes
  localparam logic [7:0] ChSp    = 8'd32;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChApos  = 8'd39;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChQuest = 8'h3f;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChZero  = 8'h30;

  typedef enum logic [18:0] {
    PH_METHOD_FIRST = 19'h00001,
    PH_METHOD       = 19'h00002,
    PH_PATH_FIRST   = 19'h00004,
    PH_SEGMENT      = 19'h00008,
    PH_ESC1         = 19'h00010,
    PH_ESC2         = 19'h00020,
    PH_QUERY        = 19'h00040,
    PH_V_H          = 19'h00080,
    PH_V_T1         = 19'h00100,
    PH_V_T2         = 19'h00200,
    PH_V_P          = 19'h00400,
    PH_V_SLASH      = 19'h00800,
    PH_V_MAJ        = 19'h01000,
    PH_V_DOT        = 19'h02000,
    PH_V_MIN        = 19'h04000,
    PH_CR           = 19'h08000,
    PH_LF           = 19'h10000,
    PH_ACCEPTED     = 19'h20000,
    PH_REJECTED     = 19'h40000
  } phase_e;

  typedef enum logic [ClassW-1:0] {
    CL_METHOD   = 4'd0,
    CL_SPACE    = 4'd1,
    CL_SLASH    = 4'd2,
    CL_SEGMENT  = 4'd3,
    CL_ESCAPE   = 4'd4,
    CL_QUESTION = 4'd5,
    CL_QUERY    = 4'd6,
    CL_VERSION  = 4'd7,
    CL_CR       = 4'd8,
    CL_LF       = 4'd9,
    CL_IGNORED  = 4'd10
  } class_e;

  typedef enum logic [StatusW-1:0] {
    ST_RUNNING  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_start;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [ClassW-1:0]   element_class;
    logic [StatusW-1:0]  line_status;
    logic [BytePosW-1:0] byte_position;
    logic [DigitW-1:0]   version_major;
    logic [DigitW-1:0]   version_minor;
  } out_word_t;

  // character class flags from the classifier to the step logic
  typedef struct packed {
    logic tchar;
    logic pchar;
    logic hex;
    logic digit;
  } char_flags_t;

endpackage

### rtl/hrlc_char_class.sv
// ----------------------------------------------------------------------------
// hrlc_char_class
// Sorts one byte into the grammar's character sets (tchar, pchar, hex, digit).
// ----------------------------------------------------------------------------
module hrlc_char_class (
  input  logic [7:0]           data_byte_i,
  output hrlc_pkg::char_flags_t flags_o
);
  import hrlc_pkg::*;

  logic is_alpha;
  logic is_digit;
  logic is_hex_letter;

  always_comb begin
    is_alpha      = (data_byte_i inside {[8'h61:8'h7a], [8'h41:8'h5a]});
    is_digit      = (data_byte_i inside {[8'h30:8'h39]});
    is_hex_letter = (data_byte_i inside {[8'h61:8'h66], [8'h41:8'h46]});

    flags_o.digit = is_digit;
    flags_o.hex   = is_digit || is_hex_letter;
    // ! # $ % & ' * + - . ^ _ ` | ~
    flags_o.tchar = is_alpha || is_digit ||
                    (data_byte_i inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, ChApos,
                                         8'h2a, 8'h2b, 8'h2d, 8'h2e, 8'h5e, 8'h5f,
                                         8'h60, 8'h7c, 8'h7e});
    // - . _ ~ : @ ! $ & ' ( ) * + , ; =
    flags_o.pchar = is_alpha || is_digit ||
                    (data_byte_i inside {8'h2d, 8'h2e, 8'h5f, 8'h7e, 8'h3a, 8'h40,
                                         8'h21, 8'h24, 8'h26, ChApos, 8'h28, 8'h29,
                                         8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d});
  end

endmodule

### rtl/hrlc_step.sv
// ----------------------------------------------------------------------------
// hrlc_step
// Line state and the per-byte transition: phase, escape origin, position
// counter and version digits, plus the result word for the current byte.
// ----------------------------------------------------------------------------
module hrlc_step #(
  parameter int unsigned POSITION_BITS = hrlc_pkg::PositionBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  hrlc_pkg::in_word_t    in_word_i,
  input  hrlc_pkg::char_flags_t flags_i,
  output hrlc_pkg::out_word_t   out_word_o
);
  import hrlc_pkg::*;

  localparam int unsigned PosExtW = (POSITION_BITS > BytePosW) ? POSITION_BITS : BytePosW;

  phase_e                   phase_q, phase_d, phase_eff, next_ph;
  logic                     esc_q, esc_d, esc_eff;
  logic [POSITION_BITS-1:0] pos_q, pos_d, pos_eff;
  logic [DigitW-1:0]        maj_q, maj_d, maj_eff;
  logic [DigitW-1:0]        min_q, min_d, min_eff;
  logic [PosExtW-1:0]       pos_ext;
  logic                     pos_big;
  logic                     ok;
  class_e                   cls;
  status_e                  status;
  logic [7:0]               c;

  always_comb begin
    c = in_word_i.data_byte;
    // a new line drops whatever the previous one left
    if (in_word_i.line_start) begin
      phase_eff = PH_METHOD_FIRST;
      esc_eff   = 1'b0;
      pos_eff   = '0;
      maj_eff   = '0;
      min_eff   = '0;
    end else begin
      phase_eff = phase_q;
      esc_eff   = esc_q;
      pos_eff   = pos_q;
      maj_eff   = maj_q;
      min_eff   = min_q;
    end

    pos_d   = (pos_eff != {POSITION_BITS{1'b1}}) ? pos_eff + 1'b1 : pos_eff;
    pos_ext = PosExtW'(pos_eff);
    pos_big = |(pos_ext >> BytePosW);

    cls     = CL_IGNORED;
    status  = ST_RUNNING;
    ok      = 1'b1;
    next_ph = phase_eff;
    esc_d   = esc_eff;
    maj_d   = maj_eff;
    min_d   = min_eff;
    phase_d = phase_eff;

    if (phase_eff == PH_ACCEPTED || phase_eff == PH_REJECTED) begin
      status = (phase_eff == PH_ACCEPTED) ? ST_ACCEPTED : ST_REJECTED;
    end else begin
      case (phase_eff)
        PH_METHOD_FIRST: begin
          ok = flags_i.tchar; cls = CL_METHOD; next_ph = PH_METHOD;
        end
        PH_METHOD: begin
          if (flags_i.tchar) begin
            cls = CL_METHOD;
          end else if (c == ChSp) begin
            cls = CL_SPACE; next_ph = PH_PATH_FIRST;
          end else begin
            ok = 1'b0;
          end
        end
        PH_PATH_FIRST: begin
          ok = (c == ChSlash); cls = CL_SLASH; next_ph = PH_SEGMENT;
        end
        PH_SEGMENT, PH_QUERY: begin
          if (flags_i.pchar) begin
            cls = (phase_eff == PH_QUERY) ? CL_QUERY : CL_SEGMENT;
          end else if (c == ChPct) begin
            cls = CL_ESCAPE; next_ph = PH_ESC1;
            esc_d = (phase_eff == PH_QUERY);
          end else if (c == ChSlash) begin
            cls = (phase_eff == PH_QUERY) ? CL_QUERY : CL_SLASH;
          end else if (c == ChQuest) begin
            if (phase_eff == PH_QUERY) begin
              cls = CL_QUERY;
            end else begin
              cls = CL_QUESTION; next_ph = PH_QUERY;
            end
          end else if (c == ChSp) begin
            cls = CL_SPACE; next_ph = PH_V_H;
          end else begin
            ok = 1'b0;
          end
        end
        PH_ESC1: begin
          ok = flags_i.hex; cls = CL_ESCAPE; next_ph = PH_ESC2;
        end
        PH_ESC2: begin
          ok = flags_i.hex; cls = CL_ESCAPE;
          next_ph = esc_eff ? PH_QUERY : PH_SEGMENT;
        end
        PH_V_H: begin
          ok = (c == ChH); cls = CL_VERSION; next_ph = PH_V_T1;
        end
        PH_V_T1: begin
          ok = (c == ChT); cls = CL_VERSION; next_ph = PH_V_T2;
        end
        PH_V_T2: begin
          ok = (c == ChT); cls = CL_VERSION; next_ph = PH_V_P;
        end
        PH_V_P: begin
          ok = (c == ChP); cls = CL_VERSION; next_ph = PH_V_SLASH;
        end
        PH_V_SLASH: begin
          ok = (c == ChSlash); cls = CL_VERSION; next_ph = PH_V_MAJ;
        end
        PH_V_MAJ: begin
          ok = flags_i.digit; cls = CL_VERSION; next_ph = PH_V_DOT;
          if (flags_i.digit) maj_d = DigitW'(c - ChZero);
        end
        PH_V_DOT: begin
          ok = (c == ChDot); cls = CL_VERSION; next_ph = PH_V_MIN;
        end
        PH_V_MIN: begin
          ok = flags_i.digit; cls = CL_VERSION; next_ph = PH_CR;
          if (flags_i.digit) min_d = DigitW'(c - ChZero);
        end
        PH_CR: begin
          ok = (c == ChCr); cls = CL_CR; next_ph = PH_LF;
        end
        PH_LF: begin
          ok = (c == ChLf); cls = CL_LF; next_ph = PH_ACCEPTED;
        end
        default: begin
          ok = 1'b0;
        end
      endcase

      if (!ok) begin
        cls = CL_IGNORED; status = ST_REJECTED; phase_d = PH_REJECTED;
      end else if (next_ph == PH_ACCEPTED) begin
        status = ST_ACCEPTED; phase_d = PH_ACCEPTED;
      end else if (in_word_i.last_byte) begin
        // buffer ran out before the line was complete
        status = ST_REJECTED; phase_d = PH_REJECTED;
      end else begin
        phase_d = next_ph;
      end
    end

    out_word_o.element_class = cls;
    out_word_o.line_status   = status;
    out_word_o.byte_position = pos_big ? {BytePosW{1'b1}} : pos_ext[BytePosW-1:0];
    out_word_o.version_major = (status == ST_ACCEPTED) ? maj_d : '0;
    out_word_o.version_minor = (status == ST_ACCEPTED) ? min_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD_FIRST;
      esc_q   <= 1'b0;
      pos_q   <= '0;
      maj_q   <= '0;
      min_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      pos_q   <= pos_d;
      maj_q   <= maj_d;
      min_q   <= min_d;
    end
  end

endmodule

### rtl/http_request_line_checker.sv
// ----------------------------------------------------------------------------
// http_request_line_checker
// Checks a request line one byte per word against the request-line grammar
// and returns element class, position, status and version digits per byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (in_word_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (out_word_t)
//
// One word per cycle while the output is not stalled; an accepted word goes
// through the input register, then the result register.
// The line state advances when the input register hands its byte to the
// result register, so the state update and the result are one step.
// A stalled output holds the result register; the input register fills and
// in_ready_o drops only when both registers are full.
// Reset clears the valid bits and puts the line state at the first method byte.
// ----------------------------------------------------------------------------
module http_request_line_checker #(
  parameter int unsigned POSITION_BITS = hrlc_pkg::PositionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hrlc_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hrlc_pkg::out_word_t out_data_o
);
  import hrlc_pkg::*;

  logic        in_valid_q;
  in_word_t    in_word_q;
  logic        out_valid_q;
  out_word_t   out_word_q;
  logic        step;
  char_flags_t flags;
  out_word_t   result;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  hrlc_char_class u_char_class (
    .data_byte_i (in_word_q.data_byte),
    .flags_o     (flags)
  );

  hrlc_step #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .in_word_i  (in_word_q),
    .flags_i    (flags),
    .out_word_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

### bench/http_request_line_checker_tb.sv
// ----------------------------------------------------------------------------
// http_request_line_checker_tb
// Streams request-line bytes through the checker under random source gaps and
// sink stalls, predicts each result word with a local grammar tracker, and
// compares every field of every result in order.
// ----------------------------------------------------------------------------
module http_request_line_checker_tb;
  import hrlc_pkg::*;

  localparam int unsigned PosBits = PositionBitsDef;
  localparam longint unsigned PosMax = (64'd1 << PosBits) - 1;
  localparam int unsigned ItemGoal = 1400;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned SatRun = 250;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  http_request_line_checker #(
    .POSITION_BITS(PosBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // line tracker state
  phase_e          ln_phase = PH_METHOD_FIRST;
  logic            ln_esc_query = 1'b0;
  longint unsigned ln_count = 0;
  logic [3:0]      ln_major = '0;
  logic [3:0]      ln_minor = '0;

  in_word_t  request_q[$];
  out_word_t verdict_q[$];
  logic [7:0] line_q[$];

  int unsigned err_cnt = 0;
  int unsigned n_seen = 0;
  int unsigned idle_cnt = 0;

  string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
  string tchar_marks = "!#$%&'*+-.^_|~";
  string pchar_marks = "-._~:@!$&'()*+,;=";
  string hex_chars = "0123456789abcdefABCDEF";

  function automatic logic is_alnum(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_tchar(logic [7:0] c);
    return is_alnum(c) || (c inside {8'h21, [8'h23:8'h27], 8'h2a, 8'h2b, 8'h2d, 8'h2e,
                                      8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e});
  endfunction

  // pchar minus the percent escape
  function automatic logic is_pchar(logic [7:0] c);
    return is_alnum(c) || (c inside {8'h21, 8'h24, [8'h26:8'h2e], 8'h3a, 8'h3b, 8'h3d,
                                      8'h40, 8'h5f, 8'h7e});
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic out_word_t check_request_byte(in_word_t w);
    out_word_t  r;
    logic [7:0] c;
    phase_e     nxt;
    class_e     cls;
    status_e    st;
    logic       ok;
    c = w.data_byte;
    if (w.line_start) begin
      ln_phase = PH_METHOD_FIRST;
      ln_esc_query = 1'b0;
      ln_count = 0;
      ln_major = '0;
      ln_minor = '0;
    end
    r = '0;
    r.byte_position = (ln_count > 64'hffff) ? 16'hffff : ln_count[15:0];
    if (ln_count < PosMax) ln_count++;
    cls = CL_IGNORED;
    st = ST_RUNNING;
    ok = 1'b1;
    nxt = ln_phase;
    if (ln_phase == PH_ACCEPTED || ln_phase == PH_REJECTED) begin
      st = (ln_phase == PH_ACCEPTED) ? ST_ACCEPTED : ST_REJECTED;
    end else begin
      case (ln_phase)
        PH_METHOD_FIRST: begin
          ok = is_tchar(c); cls = CL_METHOD; nxt = PH_METHOD;
        end
        PH_METHOD: begin
          if (is_tchar(c)) cls = CL_METHOD;
          else if (c == ChSp) begin
            cls = CL_SPACE; nxt = PH_PATH_FIRST;
          end else ok = 1'b0;
        end
        PH_PATH_FIRST: begin
          ok = (c == ChSlash); cls = CL_SLASH; nxt = PH_SEGMENT;
        end
        PH_SEGMENT, PH_QUERY: begin
          if (is_pchar(c)) begin
            cls = (ln_phase == PH_QUERY) ? CL_QUERY : CL_SEGMENT;
          end else if (c == ChPct) begin
            cls = CL_ESCAPE; nxt = PH_ESC1;
            ln_esc_query = (ln_phase == PH_QUERY);
          end else if (c == ChSlash) begin
            cls = (ln_phase == PH_QUERY) ? CL_QUERY : CL_SLASH;
          end else if (c == ChQuest) begin
            cls = (ln_phase == PH_QUERY) ? CL_QUERY : CL_QUESTION;
            nxt = PH_QUERY;
          end else if (c == ChSp) begin
            cls = CL_SPACE; nxt = PH_V_H;
          end else ok = 1'b0;
        end
        PH_ESC1: begin
          ok = is_hex(c); cls = CL_ESCAPE; nxt = PH_ESC2;
        end
        PH_ESC2: begin
          ok = is_hex(c); cls = CL_ESCAPE;
          nxt = ln_esc_query ? PH_QUERY : PH_SEGMENT;
        end
        PH_V_H:     begin ok = (c == ChH);     cls = CL_VERSION; nxt = PH_V_T1;    end
        PH_V_T1:    begin ok = (c == ChT);     cls = CL_VERSION; nxt = PH_V_T2;    end
        PH_V_T2:    begin ok = (c == ChT);     cls = CL_VERSION; nxt = PH_V_P;     end
        PH_V_P:     begin ok = (c == ChP);     cls = CL_VERSION; nxt = PH_V_SLASH; end
        PH_V_SLASH: begin ok = (c == ChSlash); cls = CL_VERSION; nxt = PH_V_MAJ;   end
        PH_V_MAJ: begin
          ok = is_digit(c); cls = CL_VERSION; nxt = PH_V_DOT;
          if (ok) ln_major = 4'(c - ChZero);
        end
        PH_V_DOT: begin ok = (c == ChDot); cls = CL_VERSION; nxt = PH_V_MIN; end
        PH_V_MIN: begin
          ok = is_digit(c); cls = CL_VERSION; nxt = PH_CR;
          if (ok) ln_minor = 4'(c - ChZero);
        end
        PH_CR: begin ok = (c == ChCr); cls = CL_CR; nxt = PH_LF;       end
        PH_LF: begin ok = (c == ChLf); cls = CL_LF; nxt = PH_ACCEPTED; end
        default: ok = 1'b0;
      endcase
      // a completing LF wins over end of buffer
      if (!ok) begin
        cls = CL_IGNORED; st = ST_REJECTED; ln_phase = PH_REJECTED;
      end else if (nxt == PH_ACCEPTED) begin
        st = ST_ACCEPTED; ln_phase = PH_ACCEPTED;
      end else if (w.last_byte) begin
        st = ST_REJECTED; ln_phase = PH_REJECTED;
      end else begin
        ln_phase = nxt;
      end
    end
    r.element_class = cls;
    r.line_status = st;
    r.version_major = (st == ST_ACCEPTED) ? ln_major : '0;
    r.version_minor = (st == ST_ACCEPTED) ? ln_minor : '0;
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    err_cnt++;
    // keep the log short when the design is badly off
    if (err_cnt <= 40) $display("mismatch: %s", msg);
  endtask

  // ---------------------------------------------------------------- driver
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) verdict_q.push_back(check_request_byte(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= request_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int unsigned stall_pct = 0;
  int unsigned mode_left = 0;
  out_word_t   want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_pct <= 0;
      mode_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_seen++;
        if (verdict_q.size() == 0) begin
          log_mismatch($sformatf("result word %0d arrived with nothing expected", n_seen));
        end else begin
          want = verdict_q.pop_front();
          if (out_data.element_class !== want.element_class)
            log_mismatch($sformatf("word %0d element_class %0d, expected %0d", n_seen,
                                   out_data.element_class, want.element_class));
          if (out_data.line_status !== want.line_status)
            log_mismatch($sformatf("word %0d line_status %0d, expected %0d", n_seen,
                                   out_data.line_status, want.line_status));
          if (out_data.byte_position !== want.byte_position)
            log_mismatch($sformatf("word %0d byte_position %0d, expected %0d", n_seen,
                                   out_data.byte_position, want.byte_position));
          if (out_data.version_major !== want.version_major)
            log_mismatch($sformatf("word %0d version_major %0d, expected %0d", n_seen,
                                   out_data.version_major, want.version_major));
          if (out_data.version_minor !== want.version_minor)
            log_mismatch($sformatf("word %0d version_minor %0d, expected %0d", n_seen,
                                   out_data.version_minor, want.version_minor));
        end
      end
      // stall pattern: stretches of fixed stall odds, zero among them
      if (mode_left == 0) begin
        mode_left <= $urandom_range(50, 300);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 25;
          2: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end else begin
        mode_left <= mode_left - 1;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_from(string chars);
    line_q.push_back(chars[$urandom_range(0, chars.len() - 1)]);
  endtask

  task automatic add_escape();
    line_q.push_back(ChPct);
    add_from(hex_chars);
    add_from(hex_chars);
  endtask

  task automatic emit_line(logic start, int last_at);
    in_word_t w;
    for (int i = 0; i < line_q.size(); i++) begin
      w.data_byte = line_q[i];
      w.line_start = start && (i == 0);
      w.last_byte = (i == last_at);
      request_q.push_back(w);
    end
  endtask

  // request line with random content, well-formed except for an occasional empty method
  task automatic build_request();
    int n;
    line_q.delete();
    n = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 7);
    repeat (n) begin
      if ($urandom_range(0, 30) == 0) line_q.push_back(8'h60);
      else if ($urandom_range(0, 2) == 0) add_from(tchar_marks);
      else add_from(alnum);
    end
    line_q.push_back(ChSp);
    repeat ($urandom_range(1, 3)) begin
      line_q.push_back(ChSlash);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 5) == 0) add_escape();
        else if ($urandom_range(0, 2) == 0) add_from(pchar_marks);
        else add_from(alnum);
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      line_q.push_back(ChQuest);
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 7))
          0: add_escape();
          1: line_q.push_back(ChSlash);
          2: line_q.push_back(ChQuest);
          3: add_from(pchar_marks);
          default: add_from(alnum);
        endcase
      end
    end
    add_text(" HTTP/");
    line_q.push_back(ChZero + 8'($urandom_range(0, 9)));
    line_q.push_back(ChDot);
    line_q.push_back(ChZero + 8'($urandom_range(0, 9)));
    line_q.push_back(ChCr);
    line_q.push_back(ChLf);
  endtask

  // negedge polling so queue and valid updates of the edge have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (request_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk_i);
  endtask

  int unsigned n_rand = 0;
  int          kind;
  int          p;
  int          last_at;
  in_word_t    noise_w;

  initial begin
    // first line comes before any line_start; escapes in path and query
    line_q.delete();
    add_text("~ /%aF?/?%0B HTTP/9.0");
    line_q.push_back(ChCr);
    line_q.push_back(ChLf);
    line_q.push_back(8'hff);
    emit_line(1'b0, -1);
    // bad hex digit in an escape
    line_q.delete();
    add_text("a /%g");
    emit_line(1'b1, -1);
    // buffer ends mid-line, then a new line abandons one mid-way
    line_q.delete();
    add_text("b /x");
    emit_line(1'b1, 3);
    line_q.delete();
    add_text("c /");
    emit_line(1'b1, -1);
    line_q.delete();
    line_q.push_back(8'h00);
    emit_line(1'b1, -1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    while (n_rand < ItemGoal) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        repeat ($urandom_range(1, 8)) begin
          noise_w.data_byte = 8'($urandom_range(0, 255));
          noise_w.line_start = ($urandom_range(0, 6) == 0);
          noise_w.last_byte = ($urandom_range(0, 9) == 0);
          request_q.push_back(noise_w);
          n_rand++;
        end
      end else begin
        build_request();
        last_at = -1;
        if (kind < 45) begin
          p = $urandom_range(0, line_q.size() - 1);
          case ($urandom_range(0, 2))
            0: line_q[p] = 8'($urandom_range(0, 255));
            1: begin
              while (line_q.size() > p + 1) void'(line_q.pop_back());
              if ($urandom_range(0, 1) == 1) last_at = p;
            end
            default: last_at = p;
          endcase
        end else if ($urandom_range(0, 9) == 0) begin
          last_at = line_q.size() - 1;
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
        end
        emit_line($urandom_range(0, 19) != 0, last_at);
        n_rand += line_q.size();
      end
    end
    wait_drained();

    // one long line keeps the position counting up to 250, within the low byte
    line_q.delete();
    line_q.push_back(8'h58);
    repeat (SatRun) line_q.push_back(8'($urandom_range(0, 255)));
    emit_line(1'b1, -1);
    build_request();
    emit_line(1'b1, -1);
    wait_drained();

    repeat (12) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
